@@ rtl/gpts_pkg.sv @@
// Package for the gyro pivot turn sequencer.
// Holds the phase, drive and register index codes, reset values and the shared structs.
// No dependencies.
package gpts_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  // Rotation margin and deadband, in degrees.
  localparam int unsigned MarginDeg = 4;
  localparam int unsigned BandDeg   = 2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_KICK   = 3'd1,
    PH_STEADY = 3'd2,
    PH_BRAKE  = 3'd3,
    PH_SETTLE = 3'd4,
    PH_NUDGE  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_FWD  = 2'd1,
    DRV_REV  = 2'd2
  } drive_e;

  typedef enum logic [2:0] {
    REG_TURN_DEGREES  = 3'd0,
    REG_TURN_CW       = 3'd1,
    REG_GYRO_OFFSET   = 3'd2,
    REG_TICKS_PER_DEG = 3'd3,
    REG_KICK_PWM      = 3'd4,
    REG_TURN_PWM      = 3'd5,
    REG_BRAKE_PWM     = 3'd6,
    REG_NUDGE_PWM     = 3'd7
  } cfg_idx_e;

  localparam logic [7:0]         RstTurnDegrees = 8'd90;
  localparam logic               RstTurnCw      = 1'b1;
  localparam logic signed [15:0] RstGyroOffset  = 16'sd0;
  localparam logic [15:0]        RstTicksPerDeg = 16'd13100;
  localparam logic [7:0]         RstKickPwm     = 8'd160;
  localparam logic [7:0]         RstTurnPwm     = 8'd85;
  localparam logic [7:0]         RstBrakePwm    = 8'd100;
  localparam logic [7:0]         RstNudgePwm    = 8'd140;

  typedef struct packed {
    logic [7:0]         angle_deg;
    logic               turn_clockwise;
    logic signed [15:0] gyro_offset;
    logic [15:0]        deg_scale;
    logic [7:0]         kick_duty;
    logic [7:0]         steady_duty;
    logic [7:0]         brake_duty;
    logic [7:0]         nudge_duty;
  } cfg_t;

  typedef struct packed {
    drive_e      left_drive;
    drive_e      right_drive;
    logic [7:0]  drive_duty;
    phase_e      turn_phase;
    logic        turn_finished;
    logic [30:0] rotation_magnitude;
  } res_t;

endpackage

@@ rtl/gpts_in_if.sv @@
// Input channel of the gyro pivot turn sequencer: valid, ready and one command beat.
// Depends on nothing.
interface gpts_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] rate_raw;

  modport source (output valid, output cmd, output rate_raw, input ready);
  modport sink   (input valid, input cmd, input rate_raw, output ready);
endinterface

@@ rtl/gpts_out_if.sv @@
// Output channel of the gyro pivot turn sequencer: valid, ready and one motor command beat.
// Depends on nothing.
interface gpts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  left_drive;
  logic [1:0]  right_drive;
  logic [7:0]  drive_duty;
  logic [2:0]  turn_phase;
  logic        turn_finished;
  logic [30:0] rotation_magnitude;

  modport source (output valid, output left_drive, output right_drive, output drive_duty,
                  output turn_phase, output turn_finished, output rotation_magnitude,
                  input ready);
  modport sink   (input valid, input left_drive, input right_drive, input drive_duty,
                  input turn_phase, input turn_finished, input rotation_magnitude,
                  output ready);
endinterface

@@ rtl/gpts_cfg_regs.sv @@
// Configuration register file of the gyro pivot turn sequencer.
// Depends on gpts_pkg.
module gpts_cfg_regs
  import gpts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_deg      <= RstTurnDegrees;
      cfg_q.turn_clockwise <= RstTurnCw;
      cfg_q.gyro_offset    <= RstGyroOffset;
      cfg_q.deg_scale      <= RstTicksPerDeg;
      cfg_q.kick_duty      <= RstKickPwm;
      cfg_q.steady_duty    <= RstTurnPwm;
      cfg_q.brake_duty     <= RstBrakePwm;
      cfg_q.nudge_duty     <= RstNudgePwm;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_TURN_DEGREES:  cfg_q.angle_deg      <= cfg_data_i[7:0];
        REG_TURN_CW:       cfg_q.turn_clockwise <= cfg_data_i[0];
        REG_GYRO_OFFSET:   cfg_q.gyro_offset    <= $signed(cfg_data_i);
        REG_TICKS_PER_DEG: cfg_q.deg_scale      <= cfg_data_i;
        REG_KICK_PWM:      cfg_q.kick_duty      <= cfg_data_i[7:0];
        REG_TURN_PWM:      cfg_q.steady_duty    <= cfg_data_i[7:0];
        REG_BRAKE_PWM:     cfg_q.brake_duty     <= cfg_data_i[7:0];
        REG_NUDGE_PWM:     cfg_q.nudge_duty     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/gpts_seq.sv @@
// Turn state registers and the single-pass step logic of the pivot turn sequencer.
// Each enabled beat updates the state and yields one motor command. Depends on gpts_pkg.
module gpts_seq
  import gpts_pkg::*;
#(
  parameter int unsigned KICK_COUNT      = 8,
  parameter int unsigned BRAKE_COUNT     = 4,
  parameter int unsigned SETTLE_COUNT    = 50,
  parameter int unsigned NUDGE_COUNT     = 4,
  parameter int unsigned MAX_CORRECTIONS = 5,
  parameter int unsigned STEADY_LIMIT    = 1200
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               cmd_i,
  input  logic signed [15:0] rate_i,
  input  cfg_t               cfg_i,
  output res_t               res_o
);

  localparam logic [5:0]  KickCnt   = 6'(KICK_COUNT);
  localparam logic [5:0]  BrakeCnt  = 6'(BRAKE_COUNT);
  localparam logic [5:0]  SettleCnt = 6'(SETTLE_COUNT);
  localparam logic [5:0]  NudgeCnt  = 6'(NUDGE_COUNT);
  localparam logic [2:0]  MaxCorr   = 3'(MAX_CORRECTIONS);
  localparam logic [10:0] SteadyLim = 11'(STEADY_LIMIT);
  localparam logic [10:0] SteadyMax = 11'h7FF;

  phase_e             phase_q, phase_d;
  logic [31:0]        sum_q, sum_d;
  logic [5:0]         left_q, left_d;
  logic [10:0]        steady_q, steady_d;
  logic [2:0]         nudges_q, nudges_d;
  logic               pcw_q, pcw_d;
  logic [24:0]        full_q, full_d;
  logic signed [25:0] early_q, early_d;

  logic signed [16:0] delta;
  logic [31:0]        sum_add;
  logic [31:0]        mag_new;
  logic [31:0]        mag_out;
  logic [5:0]         cnt_dec;
  logic               cnt_done;
  logic [10:0]        steady_inc;
  logic [10:0]        steady_cmp;
  logic               goes_on;
  logic signed [33:0] err;
  logic [33:0]        aerr;
  logic [16:0]        band;
  logic               need_nudge;
  logic               finished;
  logic [23:0]        prod;

  // Start targets: one 8x16 product, then the margin taken off.
  assign prod = cfg_i.angle_deg * cfg_i.deg_scale;

  assign delta   = $signed({rate_i[15], rate_i})
                 - $signed({cfg_i.gyro_offset[15], cfg_i.gyro_offset});
  assign sum_add = sum_q + {{15{delta[16]}}, delta};
  assign mag_new = sum_add[31] ? (32'd0 - sum_add) : sum_add;

  assign cnt_dec  = (left_q == 6'd0) ? 6'd0 : left_q - 6'd1;
  assign cnt_done = (cnt_dec == 6'd0);

  assign steady_inc = (steady_q == SteadyMax) ? steady_q : steady_q + 11'd1;
  assign steady_cmp = (phase_q == PH_STEADY) ? steady_inc : steady_q;
  // A stop target that is not positive never lets the steady phase run.
  assign goes_on = !early_q[25] && (early_q != 26'sd0)
                && (mag_new < {7'd0, early_q[24:0]})
                && (steady_cmp < SteadyLim);

  assign err  = $signed({9'd0, full_q}) - $signed({2'd0, mag_new});
  assign aerr = err[33] ? (34'd0 - err) : err;
  assign band = {cfg_i.deg_scale, 1'b0};
  assign need_nudge = (nudges_q < MaxCorr) && (aerr > {17'd0, band});

  always_comb begin
    phase_d  = phase_q;
    sum_d    = sum_q;
    left_d   = left_q;
    steady_d = steady_q;
    nudges_d = nudges_q;
    pcw_d    = pcw_q;
    full_d   = full_q;
    early_d  = early_q;
    finished = 1'b0;
    if (!cmd_i) begin
      sum_d    = '0;
      full_d   = {1'b0, prod};
      early_d  = $signed({2'd0, prod}) - $signed({8'd0, cfg_i.deg_scale, 2'b00});
      nudges_d = '0;
      steady_d = '0;
      phase_d  = PH_KICK;
      left_d   = KickCnt;
      pcw_d    = cfg_i.turn_clockwise;
    end else if (phase_q != PH_IDLE) begin
      sum_d = sum_add;
      case (phase_q)
        PH_KICK: begin
          left_d = cnt_dec;
          if (cnt_done) begin
            if (goes_on) begin
              phase_d = PH_STEADY;
              left_d  = '0;
              pcw_d   = cfg_i.turn_clockwise;
            end else begin
              phase_d = PH_BRAKE;
              left_d  = BrakeCnt;
              pcw_d   = !cfg_i.turn_clockwise;
            end
          end
        end
        PH_STEADY: begin
          steady_d = steady_inc;
          if (!goes_on) begin
            phase_d = PH_BRAKE;
            left_d  = BrakeCnt;
            pcw_d   = !cfg_i.turn_clockwise;
          end
        end
        PH_BRAKE, PH_NUDGE: begin
          left_d = cnt_dec;
          if (cnt_done) begin
            phase_d = PH_SETTLE;
            left_d  = SettleCnt;
            pcw_d   = 1'b0;
          end
        end
        PH_SETTLE: begin
          left_d = cnt_dec;
          if (cnt_done) begin
            if (need_nudge) begin
              nudges_d = nudges_q + 3'd1;
              phase_d  = PH_NUDGE;
              left_d   = NudgeCnt;
              // Undershoot pushes on in the turn direction, overshoot pulls back.
              pcw_d    = (!err[33] && (err != 34'sd0)) ? cfg_i.turn_clockwise
                                                       : !cfg_i.turn_clockwise;
            end else begin
              phase_d  = PH_IDLE;
              left_d   = '0;
              pcw_d    = 1'b0;
              finished = 1'b1;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
          left_d  = '0;
          pcw_d   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      sum_q    <= '0;
      left_q   <= '0;
      steady_q <= '0;
      nudges_q <= '0;
      pcw_q    <= 1'b0;
      full_q   <= '0;
      early_q  <= '0;
    end else if (en_i) begin
      phase_q  <= phase_d;
      sum_q    <= sum_d;
      left_q   <= left_d;
      steady_q <= steady_d;
      nudges_q <= nudges_d;
      pcw_q    <= pcw_d;
      full_q   <= full_d;
      early_q  <= early_d;
    end
  end

  assign mag_out = sum_d[31] ? (32'd0 - sum_d) : sum_d;

  always_comb begin
    res_o.turn_phase    = phase_d;
    res_o.turn_finished = finished;
    res_o.rotation_magnitude = mag_out[31] ? 31'h7FFF_FFFF : mag_out[30:0];
    res_o.left_drive    = DRV_STOP;
    res_o.right_drive   = DRV_STOP;
    case (phase_d)
      PH_KICK:   res_o.drive_duty = cfg_i.kick_duty;
      PH_STEADY: res_o.drive_duty = cfg_i.steady_duty;
      PH_BRAKE:  res_o.drive_duty = cfg_i.brake_duty;
      PH_NUDGE:  res_o.drive_duty = cfg_i.nudge_duty;
      default:   res_o.drive_duty = '0;
    endcase
    if (phase_d inside {PH_KICK, PH_STEADY, PH_BRAKE, PH_NUDGE}) begin
      res_o.left_drive  = pcw_d ? DRV_FWD : DRV_REV;
      res_o.right_drive = pcw_d ? DRV_REV : DRV_FWD;
    end
  end

endmodule

@@ rtl/gyro_pivot_turn_sequencer.sv @@
// Gyro pivot turn sequencer.
// Top level: holds the input and result registers around the step logic.
// Depends on gpts_pkg, gpts_in_if, gpts_out_if, gpts_cfg_regs and gpts_seq.
//
// Use: each input beat on in_ch_i is either a start command (cmd 0) or one gyro
// sample (cmd 1 with a raw rate reading). Every input beat yields exactly one motor
// command beat on out_ch_o: drive directions for both motors, the duty, the phase in
// force, a finished flag on the beat that ends the turn, and the rotation magnitude.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) writes one register
// per cycle and should be used only while no beat is in flight.
// A beat taken in passes through the input register and then the result register.
// Throughput: one beat per cycle unless the receiver stalls; the rotation add, abs
// and target compares fit between the input register and the result register.
// Reset sets the configuration registers to their defaults, the turn state to idle
// and both channels to empty. When the receiver stalls, the result register holds
// its beat, the input register fills, and ready drops until the result is taken.
module gyro_pivot_turn_sequencer
  import gpts_pkg::*;
#(
  parameter int unsigned KICK_COUNT      = 8,
  parameter int unsigned BRAKE_COUNT     = 4,
  parameter int unsigned SETTLE_COUNT    = 50,
  parameter int unsigned NUDGE_COUNT     = 4,
  parameter int unsigned MAX_CORRECTIONS = 5,
  parameter int unsigned STEADY_LIMIT    = 1200
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  gpts_in_if.sink             in_ch_i,
  gpts_out_if.source          out_ch_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t               cfg;
  res_t               res;
  res_t               res_q;
  logic               in_valid_q;
  logic               cmd_q;
  logic signed [15:0] rate_q;
  logic               out_valid_q;
  logic               advance;
  logic               fire;

  assign advance       = !out_valid_q || out_ch_o.ready;
  assign fire          = in_valid_q && advance;
  assign in_ch_i.ready = !in_valid_q || advance;

  gpts_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  gpts_seq #(
    .KICK_COUNT      (KICK_COUNT),
    .BRAKE_COUNT     (BRAKE_COUNT),
    .SETTLE_COUNT    (SETTLE_COUNT),
    .NUDGE_COUNT     (NUDGE_COUNT),
    .MAX_CORRECTIONS (MAX_CORRECTIONS),
    .STEADY_LIMIT    (STEADY_LIMIT)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire),
    .cmd_i  (cmd_q),
    .rate_i (rate_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ch_i.ready) begin
        in_valid_q <= in_ch_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.valid && in_ch_i.ready) begin
      cmd_q  <= in_ch_i.cmd;
      rate_q <= in_ch_i.rate_raw;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_ch_o.valid              = out_valid_q;
  assign out_ch_o.left_drive         = res_q.left_drive;
  assign out_ch_o.right_drive        = res_q.right_drive;
  assign out_ch_o.drive_duty         = res_q.drive_duty;
  assign out_ch_o.turn_phase         = res_q.turn_phase;
  assign out_ch_o.turn_finished      = res_q.turn_finished;
  assign out_ch_o.rotation_magnitude = res_q.rotation_magnitude;

endmodule

@@ rtl/gpts_checker.sv @@
// Port-level checks on the motor command channel of the pivot turn sequencer,
// with the bind that attaches them to the top level. Depends on gpts_pkg.
module gpts_checker
  import gpts_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  left_drive_i,
  input logic [1:0]  right_drive_i,
  input logic [7:0]  drive_duty_i,
  input logic [2:0]  turn_phase_i,
  input logic        turn_finished_i,
  input logic [30:0] rotation_magnitude_i
);

  // A stalled beat keeps its whole command.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(left_drive_i)
      && $stable(right_drive_i) && $stable(drive_duty_i) && $stable(turn_phase_i)
      && $stable(turn_finished_i) && $stable(rotation_magnitude_i))
    else $error("stalled result beat changed");

  // The ending beat leaves the motors stopped and the sequencer idle.
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && turn_finished_i |-> turn_phase_i == PH_IDLE
      && drive_duty_i == 8'd0 && left_drive_i == DRV_STOP && right_drive_i == DRV_STOP)
    else $error("finished beat does not stop the motors");

  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (turn_phase_i == PH_IDLE || turn_phase_i == PH_SETTLE)
      |-> drive_duty_i == 8'd0 && left_drive_i == DRV_STOP && right_drive_i == DRV_STOP)
    else $error("motors driven in idle or settle");

  // Driving phases always pivot: the two motors run in opposite directions.
  a_pivot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (turn_phase_i == PH_KICK || turn_phase_i == PH_STEADY
      || turn_phase_i == PH_BRAKE || turn_phase_i == PH_NUDGE)
      |-> left_drive_i != DRV_STOP && right_drive_i != DRV_STOP
      && left_drive_i != right_drive_i)
    else $error("driving phase without a pivot command");

endmodule

bind gyro_pivot_turn_sequencer gpts_checker u_gpts_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_ch_o.valid),
  .out_ready_i          (out_ch_o.ready),
  .left_drive_i         (out_ch_o.left_drive),
  .right_drive_i        (out_ch_o.right_drive),
  .drive_duty_i         (out_ch_o.drive_duty),
  .turn_phase_i         (out_ch_o.turn_phase),
  .turn_finished_i      (out_ch_o.turn_finished),
  .rotation_magnitude_i (out_ch_o.rotation_magnitude)
);
